// ----- rtl/core/sui_pkg.sv -----
`default_nettype none

package sui_pkg;

    // Field widths of the item ports.
    localparam int FREQ_W = 14;
    localparam int HGT_W  = 10;
    localparam int DIST_W = 17;
    localparam int PL_W   = 19;

    // Terrain codes; every other code selects the urban set.
    localparam logic [1:0] TERRAIN_SUBURBAN = 2'd2;
    localparam logic [1:0] TERRAIN_RURAL    = 2'd3;
    localparam logic [1:0] TERRAIN_RESET    = 2'd1;

    // Fixed-point constants, Q16 dB unless noted.
    localparam logic [14:0] LOG10_2_Q16 = 15'd19728;
    localparam int FSPL_K_Q16     = 815384;
    localparam int LOG10_2000_Q16 = 216336;
    localparam int LOG10_20_Q16   = 85264;
    localparam int FADE_Q16       = 694682;
    localparam int DIST_OFFSET    = 131072;
    localparam int FREQ_GAIN      = 26;
    localparam int FTERM_K        = FSPL_K_Q16 - 6 * LOG10_2000_Q16 + FADE_Q16;
    localparam int OUT_MIN        = -65536;
    localparam int OUT_MAX        = 262143;

    // Divider for 10*c*2^30 / Ht: one quotient bit per step.
    localparam int Q30_SHIFT = 30;
    localparam int CK_W      = 8;
    localparam int DVS_W     = HGT_W;
    localparam int Q_W       = 38;
    localparam int DIV_SPS   = 8;
    localparam int DIV_W     = 40;
    localparam int DIV_ST    = DIV_W / DIV_SPS;

    typedef struct packed {
        logic [32:0] a;
        logic [19:0] b10;
        logic [CK_W-1:0] ck;
        logic [20:0] xq;
    } coef_t;

    function automatic coef_t terrain_coef(input logic [1:0] mode);
        coef_t c;
        unique case (mode)
            TERRAIN_SUBURBAN:
            begin
                c.a   = 33'd4294967296;
                c.b10 = 20'd697932;
                c.ck  = 8'd171;
                c.xq  = 21'd707789;
            end
            TERRAIN_RURAL:
            begin
                c.a   = 33'd3865470566;
                c.b10 = 20'd536871;
                c.ck  = 8'd200;
                c.xq  = 21'd1310720;
            end
            default:
            begin
                c.a   = 33'd4939212390;
                c.b10 = 20'd805306;
                c.ck  = 8'd126;
                c.xq  = 21'd707789;
            end
        endcase
        return c;
    endfunction

    // Sixteen fraction bits of log2(m / 2^tbits) by repeated squaring in Q30.
    // Only evaluated at elaboration to build the lookup tables.
    function automatic logic [15:0] log2_entry(input int unsigned m, input int unsigned tbits);
        logic [63:0] z;
        logic [15:0] frac;
        z = 64'(m) << (30 - tbits);
        frac = '0;
        for (int k = 0; k < 16; k++)
        begin
            z = (z * z) >> 30;
            frac = {frac[14:0], 1'b0};
            if (z >= 64'h8000_0000)
            begin
                frac[0] = 1'b1;
                z = z >> 1;
            end
        end
        return frac;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sui_path_loss.sv -----
// SUI path loss, one point per item.
// Input channel in_valid/in_ready carries frequency, transmitter height, receiver height and
// distance; output channel out_valid/out_ready carries the loss in 1/2^FRAC_BITS dB,
// saturated to -65536 .. 262143. The terrain coefficient set comes from a two-bit register
// written through cfg_we/cfg_wdata while no item is in flight: 2 selects suburban, 3 rural,
// any other code urban.
// The datapath is an eleven-stage pipeline, and one item is taken every cycle while the
// receiver is ready. The depth is set by the five-stage divider that forms c/Ht at eight
// quotient bits per stage, followed by the split 38 x 19 bit multiply of the distance term
// and its rounding.
// Each stage holds a valid bit and advances whenever it is empty or the stage after it
// moves, so a stalled receiver does not stop the pipeline from filling its gaps; in_ready
// falls only when all eleven stages hold items. out_ready high always keeps in_ready high.
// Reset clears every valid bit and sets the terrain register to 1 (urban). Payload
// registers are not reset.
`default_nettype none

module sui_path_loss
    import sui_pkg::*;
#(
    parameter int LOG_TABLE_BITS = 8,
    parameter int FRAC_BITS = 8
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_wdata,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [FREQ_W-1:0]        freq_mhz,
    input  wire logic [HGT_W-1:0]         tx_height_dm,
    input  wire logic [HGT_W-1:0]         rx_height_dm,
    input  wire logic [DIST_W-1:0]        distance_m,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [PL_W-1:0]        path_loss_q8
);

    localparam int NS      = 11;
    localparam int TW      = 31;
    localparam int Y_SPLIT = 19;
    localparam int LF_W    = 16 + $clog2(FREQ_W);
    localparam int LR_W    = 16 + $clog2(HGT_W);
    localparam int LD_W    = 16 + $clog2(DIST_W);
    localparam int SH      = 16 - FRAC_BITS;
    localparam logic signed [TW-1:0] HALF = TW'((1 << SH) >> 1);
    localparam logic signed [60:0] ROUND_Q30 = 61'(1) <<< 29;

    // Pipeline control: stage k advances when empty or when stage k+1 advances.
    logic [NS-1:0] v_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = out_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];

    logic [1:0] terrain_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            terrain_mode_reg <= TERRAIN_RESET;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= (k == 0) ? in_valid : v_reg[k-1 < 0 ? 0 : k-1];
                end
            end
            if (cfg_we)
            begin
                terrain_mode_reg <= cfg_wdata;
            end
        end
    end

    // The register is to change only while the pipeline is empty; the block does not enforce
    // this, and every stage reads it directly.
    coef_t coef;
    logic [HGT_W-1:0] tx_fix;

    assign coef   = terrain_coef(terrain_mode_reg);
    assign tx_fix = (tx_height_dm == '0) ? HGT_W'(1) : tx_height_dm;

    // Logarithms, valid at the end of stage 1.
    logic [LF_W-1:0] lf;
    logic [LR_W-1:0] lr;
    logic [LD_W-1:0] ld;

    sui_log #(.WIDTH(FREQ_W), .TBITS(LOG_TABLE_BITS)) u_log_f
    (
        .clk  (clk),
        .en   (en[1:0]),
        .x    (freq_mhz),
        .lg10 (lf)
    );

    sui_log #(.WIDTH(HGT_W), .TBITS(LOG_TABLE_BITS)) u_log_r
    (
        .clk  (clk),
        .en   (en[1:0]),
        .x    (rx_height_dm),
        .lg10 (lr)
    );

    sui_log #(.WIDTH(DIST_W), .TBITS(LOG_TABLE_BITS)) u_log_d
    (
        .clk  (clk),
        .en   (en[1:0]),
        .x    (distance_m),
        .lg10 (ld)
    );

    // Quotient 10*c*2^30 / tx, valid at the end of stage 4.
    logic [Q_W-1:0] quo;

    sui_div u_div
    (
        .clk (clk),
        .en  (en[DIV_ST-1:0]),
        .ck  (coef.ck),
        .dvs (tx_fix),
        .quo (quo)
    );

    // Datapath registers, named by the stage that writes them.
    logic [29:0]        bt_s0_reg;
    logic [32:0]        amb_s1_reg, amb_s2_reg, amb_s3_reg, amb_s4_reg;
    logic [23:0]        fterm_s2_reg;
    logic signed [18:0] ldp_s2_reg, ldp_s3_reg, ldp_s4_reg, ldp_s5_reg;
    logic signed [38:0] xprod_s2_reg;
    logic signed [24:0] sum1_s3_reg, sum1_s4_reg, sum1_s5_reg, sum1_s6_reg;
    logic signed [24:0] sum1_s7_reg, sum1_s8_reg;
    logic [Q_W-1:0]     y_s5_reg;
    logic signed [38:0] pl_s6_reg, ph_s6_reg;
    logic signed [57:0] p_s7_reg;
    logic signed [60:0] p10_s8_reg;
    logic signed [TW-1:0] total_s9_reg;
    logic signed [PL_W-1:0] pl_out_reg;

    logic [29:0]          bt_next;
    logic [32:0]          amb_next;
    logic [23:0]          fterm_next;
    logic signed [LD_W:0] ldp_full;
    logic signed [LR_W:0] lrp_full;
    logic signed [42:0]   xprod_full;
    logic signed [38:0]   xr;
    logic signed [22:0]   xh;
    logic signed [24:0]   sum1_next;
    logic [Q_W-1:0]       y_next;
    logic signed [38:0]   pl_next, ph_next;
    logic signed [57:0]   p_next;
    logic signed [60:0]   p10_next;
    logic signed [60:0]   dr;
    logic signed [TW-1:0] total_next;
    logic signed [TW-1:0] rs;
    logic signed [PL_W-1:0] out_next;

    always_comb
    begin
        // Stage 0: b*Ht term of the path-loss exponent.
        bt_next = 30'(coef.b10) * 30'(tx_fix);
        // Stage 1: a - b*Ht.
        amb_next = coef.a - 33'(bt_s0_reg);
        // Stage 2: free-space, frequency and fading terms, distance log offset and the
        // receiver-height product.
        fterm_next = 24'(lf) * 24'(FREQ_GAIN) + 24'(FTERM_K);
        ldp_full = $signed({1'b0, ld}) - (LD_W + 1)'(DIST_OFFSET);
        lrp_full = $signed({1'b0, lr}) - (LR_W + 1)'(LOG10_20_Q16);
        xprod_full = $signed({1'b0, coef.xq}) * lrp_full;
        // Stage 3: subtract the rounded receiver-height correction.
        xr = xprod_s2_reg + 39'sd32768;
        xh = xr[38:16];
        sum1_next = $signed({1'b0, fterm_s2_reg}) - 25'(xh);
        // Stage 5: full exponent y in Q30.
        y_next = 38'(amb_s4_reg) + quo;
        // Stage 6: y times the distance log, in two halves.
        pl_next = $signed({1'b0, y_s5_reg[Y_SPLIT-1:0]}) * ldp_s5_reg;
        ph_next = $signed({1'b0, y_s5_reg[Q_W-1:Y_SPLIT]}) * ldp_s5_reg;
        // Stage 7 and 8: combine the halves, then scale by ten.
        p_next = (58'(ph_s6_reg) <<< Y_SPLIT) + 58'(pl_s6_reg);
        p10_next = (61'(p_s7_reg) <<< 3) + (61'(p_s7_reg) <<< 1);
        // Stage 9: round the distance term back to Q16 and add the rest.
        dr = p10_s8_reg + ROUND_Q30;
        total_next = TW'(sum1_s8_reg) + $signed(dr[60:30]);
        // Stage 10: round to the output fraction and saturate.
        rs = (total_s9_reg + HALF) >>> SH;
        if (rs < TW'(OUT_MIN))
        begin
            out_next = PL_W'(OUT_MIN);
        end
        else if (rs > TW'(OUT_MAX))
        begin
            out_next = PL_W'(OUT_MAX);
        end
        else
        begin
            out_next = rs[PL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            bt_s0_reg <= bt_next;
        end
        if (en[1])
        begin
            amb_s1_reg <= amb_next;
        end
        if (en[2])
        begin
            amb_s2_reg   <= amb_s1_reg;
            fterm_s2_reg <= fterm_next;
            ldp_s2_reg   <= ldp_full[18:0];
            xprod_s2_reg <= xprod_full[38:0];
        end
        if (en[3])
        begin
            amb_s3_reg  <= amb_s2_reg;
            ldp_s3_reg  <= ldp_s2_reg;
            sum1_s3_reg <= sum1_next;
        end
        if (en[4])
        begin
            amb_s4_reg  <= amb_s3_reg;
            ldp_s4_reg  <= ldp_s3_reg;
            sum1_s4_reg <= sum1_s3_reg;
        end
        if (en[5])
        begin
            y_s5_reg    <= y_next;
            ldp_s5_reg  <= ldp_s4_reg;
            sum1_s5_reg <= sum1_s4_reg;
        end
        if (en[6])
        begin
            pl_s6_reg   <= pl_next;
            ph_s6_reg   <= ph_next;
            sum1_s6_reg <= sum1_s5_reg;
        end
        if (en[7])
        begin
            p_s7_reg    <= p_next;
            sum1_s7_reg <= sum1_s6_reg;
        end
        if (en[8])
        begin
            p10_s8_reg  <= p10_next;
            sum1_s8_reg <= sum1_s7_reg;
        end
        if (en[9])
        begin
            total_s9_reg <= total_next;
        end
        if (en[10])
        begin
            pl_out_reg <= out_next;
        end
    end

    assign path_loss_q8 = pl_out_reg;

    // A delivered result never lies below the lower saturation bound.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (path_loss_q8 >= PL_W'(OUT_MIN)))
        else $error("path loss below saturation bound");

    // Gaps in the pipeline are always filled before the input is held off.
    a_full_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&v_reg))
        else $error("input held off while a stage is empty");

    // A ready receiver lets the whole pipeline move.
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input held off although the receiver is ready");

endmodule

`default_nettype wire

// ----- rtl/core/sui_log.sv -----
`default_nettype none

// Two-stage log10 in Q16: leading-one search and table lookup, then a scale by log10(2).
module sui_log
    import sui_pkg::*;
#(
    parameter int WIDTH = 17,
    parameter int TBITS = 8,
    localparam int EW = $clog2(WIDTH),
    localparam int LW = 16 + EW
)
(
    input  wire logic             clk,
    input  wire logic [1:0]       en,
    input  wire logic [WIDTH-1:0] x,
    output logic      [LW-1:0]    lg10
);

    localparam int XW = WIDTH + TBITS;
    localparam int PW = LW + 15;

    logic [15:0]       tab [2**TBITS];
    logic [WIDTH-1:0]  xs;
    logic [EW-1:0]     e;
    logic [XW-1:0]     xe;
    logic [TBITS-1:0]  idx;
    logic [LW-1:0]     l2_next;
    logic [LW-1:0]     l2_reg;
    logic [PW-1:0]     prod;
    logic [LW-1:0]     lg10_reg;

    for (genvar gi = 0; gi < 2**TBITS; gi++)
    begin : g_tab
        assign tab[gi] = log2_entry((2**TBITS) + gi, TBITS);
    end

    always_comb
    begin
        xs = (x == '0) ? WIDTH'(1) : x;
        e = '0;
        for (int i = 1; i < WIDTH; i++)
        begin
            if (xs[i])
            begin
                e = EW'(i);
            end
        end
        // Move the leading one to the top; the bits below it index the table.
        xe = {xs, {TBITS{1'b0}}} << (EW'(WIDTH - 1) - e);
        idx = xe[XW-2 -: TBITS];
        l2_next = {e, tab[idx]};
        prod = PW'(l2_reg) * PW'(LOG10_2_Q16) + PW'(32768);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            l2_reg <= l2_next;
        end
        if (en[1])
        begin
            lg10_reg <= LW'(prod >> 16);
        end
    end

    assign lg10 = lg10_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sui_div.sv -----
`default_nettype none

// Pipelined restoring divider: (ck * 2^30) / dvs, DIV_SPS quotient bits per stage.
module sui_div
    import sui_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [DIV_ST-1:0] en,
    input  wire logic [CK_W-1:0]   ck,
    input  wire logic [DVS_W-1:0]  dvs,
    output logic      [Q_W-1:0]    quo
);

    logic [DVS_W-1:0] rem_reg [DIV_ST-1];
    logic [DVS_W-1:0] dvs_reg [DIV_ST-1];
    logic [DIV_W-1:0] w_reg   [DIV_ST];

    for (genvar st = 0; st < DIV_ST; st++)
    begin : g_st
        logic [DVS_W-1:0] rem_in;
        logic [DVS_W-1:0] d_in;
        logic [DIV_W-1:0] w_in;
        logic [DVS_W-1:0] rem_next;
        logic [DIV_W-1:0] w_next;
        logic [DVS_W:0]   t;

        if (st == 0)
        begin : g_first
            assign rem_in = '0;
            assign d_in   = dvs;
            assign w_in   = DIV_W'({ck, {Q30_SHIFT{1'b0}}});
        end
        else
        begin : g_next
            assign rem_in = rem_reg[st-1];
            assign d_in   = dvs_reg[st-1];
            assign w_in   = w_reg[st-1];
        end

        // The dividend shifts out of the top of w while quotient bits enter below.
        always_comb
        begin
            rem_next = rem_in;
            w_next = w_in;
            t = '0;
            for (int i = 0; i < DIV_SPS; i++)
            begin
                t = {rem_next, w_next[DIV_W-1]};
                w_next = {w_next[DIV_W-2:0], 1'b0};
                if (t >= {1'b0, d_in})
                begin
                    rem_next = DVS_W'(t - {1'b0, d_in});
                    w_next[0] = 1'b1;
                end
                else
                begin
                    rem_next = t[DVS_W-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[st])
            begin
                w_reg[st] <= w_next;
            end
        end

        if (st < DIV_ST - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en[st])
                begin
                    rem_reg[st] <= rem_next;
                    dvs_reg[st] <= d_in;
                end
            end
        end
    end

    assign quo = w_reg[DIV_ST-1][Q_W-1:0];

endmodule

`default_nettype wire
